>>> src/assert_macros.svh
// Assertion macros shared by the RTL of the LRC time tag parser.
// No dependencies; files that assert include this header by its bare name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) else $error(msg);

// A consequent that must hold in the same cycle as its antecedent.
`define ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// A consequent that must hold in the cycle after its antecedent.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/lrc_ttp_pkg.sv
// Types and constants for the LRC time tag parser.
// No dependencies; used by lrc_time_tag_parser_unit.
package lrc_ttp_pkg;

    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_MIN        = 3'd1,
        PH_SEC        = 3'd2,
        PH_FRAC       = 3'd3,
        PH_TAIL_START = 3'd4,
        PH_TAIL       = 3'd5
    } phase_t;

    localparam int CHAR_W = 8;
    localparam int TIME_W = 26;
    localparam int MIN_W  = 10;
    localparam int SEC_W  = 7;
    localparam int FRAC_W = 10;
    localparam int CNT_W  = 2;

    localparam logic [CHAR_W-1:0] CH_OPEN  = 8'h5B;
    localparam logic [CHAR_W-1:0] CH_CLOSE = 8'h5D;
    localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    localparam logic [TIME_W-1:0] MS_PER_MIN = 26'd60000;
    localparam logic [TIME_W-1:0] MS_PER_SEC = 26'd1000;
    localparam logic [TIME_W-1:0] TIME_MAX   = 26'd60039999;

    localparam logic [CNT_W-1:0] MIN_DIGITS_MAX  = 2'd3;
    localparam logic [CNT_W-1:0] SEC_DIGITS_MAX  = 2'd2;
    localparam logic [CNT_W-1:0] FRAC_DIGITS_MAX = 2'd3;

endpackage

>>> src/lrc_time_tag_parser_unit.sv
// Top level of the LRC time tag parser: byte stream in, tag times in ms out.
// Depends on lrc_ttp_pkg and assert_macros.svh.
//
//   Channel | Ports      | Beat contents (lowest bit first)
//   --------+------------+------------------------------------------
//   input   | s_t*       | tdata[7:0] char_byte
//   result  | m_t*       | tdata[25:0] tag_time_ms, tdata[31:26] zero
//
// One byte per cycle is taken unless a ']' beat waits; a byte is parsed from the input
// register, and a ']' beat's tag time is then registered in the result register.
// The input register feeds the parser and the result register holds one time.
// A ']' beat waits in the input register while an earlier time is still unread;
// bytes that close no tag keep flowing while a result waits to be taken.
// Reset (aresetn low, synchronous) empties both registers and closes any tag.
`include "assert_macros.svh"

module lrc_time_tag_parser_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [25:0] tag_time_ms, [31:26] zero
);
    import lrc_ttp_pkg::*;

    logic              in_valid_reg, in_valid_next;
    logic [CHAR_W-1:0] in_byte_reg;
    logic              out_valid_reg, out_valid_next;
    logic [TIME_W-1:0] out_time_reg, out_time_next;

    phase_t            phase_reg, phase_next;
    logic [MIN_W-1:0]  min_val_reg, min_val_next;
    logic [CNT_W-1:0]  min_cnt_reg, min_cnt_next;
    logic [SEC_W-1:0]  sec_val_reg, sec_val_next;
    logic [CNT_W-1:0]  sec_cnt_reg, sec_cnt_next;
    logic [FRAC_W-1:0] frac_val_reg, frac_val_next;
    logic [CNT_W-1:0]  frac_cnt_reg, frac_cnt_next;
    logic              sep_dot_reg, sep_dot_next;

    logic              is_digit;
    logic [3:0]        digit;
    logic              emit;
    logic              out_free;
    logic              proceed;
    logic [TIME_W-1:0] frac_ms;
    logic [TIME_W-1:0] tag_time;

    assign is_digit = (in_byte_reg >= CH_ZERO) && (in_byte_reg <= CH_NINE);
    assign digit    = is_digit ? in_byte_reg[3:0] : 4'd0;
    assign out_free = !out_valid_reg || m_tready;
    assign proceed  = in_valid_reg && (out_free || !emit);
    assign s_tready = !in_valid_reg || proceed;

    always_comb begin
        case (frac_cnt_reg)
            2'd1:    frac_ms = TIME_W'(frac_val_reg) * TIME_W'(100);
            2'd2:    frac_ms = TIME_W'(frac_val_reg) * TIME_W'(10);
            2'd3:    frac_ms = TIME_W'(frac_val_reg);
            default: frac_ms = '0;
        endcase
        tag_time = TIME_W'(min_val_reg) * MS_PER_MIN + TIME_W'(sec_val_reg) * MS_PER_SEC
                   + frac_ms;
    end

    always_comb begin
        phase_next    = PH_IDLE;
        min_val_next  = min_val_reg;
        min_cnt_next  = min_cnt_reg;
        sec_val_next  = sec_val_reg;
        sec_cnt_next  = sec_cnt_reg;
        frac_val_next = frac_val_reg;
        frac_cnt_next = frac_cnt_reg;
        sep_dot_next  = sep_dot_reg;
        emit          = 1'b0;

        if (in_byte_reg == CH_OPEN) begin
            phase_next = PH_MIN;
        end else begin
            case (phase_reg)
                PH_MIN: begin
                    if (is_digit && min_cnt_reg < MIN_DIGITS_MAX) begin
                        min_val_next = MIN_W'(min_val_reg * MIN_W'(10) + MIN_W'(digit));
                        min_cnt_next = min_cnt_reg + 2'd1;
                        phase_next   = PH_MIN;
                    end else if (in_byte_reg == CH_COLON && min_cnt_reg != 2'd0) begin
                        phase_next = PH_SEC;
                    end
                end
                PH_SEC: begin
                    if (is_digit && sec_cnt_reg < SEC_DIGITS_MAX) begin
                        sec_val_next = SEC_W'(sec_val_reg * SEC_W'(10) + SEC_W'(digit));
                        sec_cnt_next = sec_cnt_reg + 2'd1;
                        phase_next   = PH_SEC;
                    end else if (sec_cnt_reg != 2'd0) begin
                        if (in_byte_reg == CH_CLOSE) begin
                            emit = 1'b1;
                        end else if (in_byte_reg == CH_DOT) begin
                            sep_dot_next = 1'b1;
                            phase_next   = PH_FRAC;
                        end else if (in_byte_reg == CH_COLON) begin
                            sep_dot_next = 1'b0;
                            phase_next   = PH_FRAC;
                        end
                    end
                end
                PH_FRAC: begin
                    if (is_digit) begin
                        if (frac_cnt_reg < FRAC_DIGITS_MAX) begin
                            frac_val_next = FRAC_W'(frac_val_reg * FRAC_W'(10)
                                                    + FRAC_W'(digit));
                            frac_cnt_next = frac_cnt_reg + 2'd1;
                            phase_next    = PH_FRAC;
                        end else if (sep_dot_reg) begin
                            frac_val_next = '0;
                            frac_cnt_next = '0;
                            phase_next    = PH_TAIL;
                        end
                    end else if (frac_cnt_reg != 2'd0) begin
                        if (in_byte_reg == CH_CLOSE) begin
                            emit = 1'b1;
                        end else if (in_byte_reg == CH_DOT) begin
                            phase_next = PH_TAIL_START;
                        end
                    end
                end
                PH_TAIL_START: begin
                    if (is_digit) begin
                        phase_next = PH_TAIL;
                    end
                end
                PH_TAIL: begin
                    if (is_digit) begin
                        phase_next = PH_TAIL;
                    end else if (in_byte_reg == CH_CLOSE) begin
                        emit = 1'b1;
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end

        // A new tag and a dropped tag both start from cleared fields.
        if (in_byte_reg == CH_OPEN || phase_next == PH_IDLE) begin
            min_val_next  = '0;
            min_cnt_next  = '0;
            sec_val_next  = '0;
            sec_cnt_next  = '0;
            frac_val_next = '0;
            frac_cnt_next = '0;
            sep_dot_next  = 1'b0;
        end
    end

    always_comb begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        out_time_next  = out_time_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
        end
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        if (proceed && emit) begin
            out_valid_next = 1'b1;
            out_time_next  = tag_time;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_IDLE;
            min_val_reg   <= '0;
            min_cnt_reg   <= '0;
            sec_val_reg   <= '0;
            sec_cnt_reg   <= '0;
            frac_val_reg  <= '0;
            frac_cnt_reg  <= '0;
            sep_dot_reg   <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (proceed) begin
                phase_reg    <= phase_next;
                min_val_reg  <= min_val_next;
                min_cnt_reg  <= min_cnt_next;
                sec_val_reg  <= sec_val_next;
                sec_cnt_reg  <= sec_cnt_next;
                frac_val_reg <= frac_val_next;
                frac_cnt_reg <= frac_cnt_next;
                sep_dot_reg  <= sep_dot_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
        out_time_reg <= out_time_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(32 - TIME_W){1'b0}}, out_time_reg};

    `ASSERT_ALWAYS(a_time_range, aclk, aresetn, !out_valid_reg || out_time_reg <= TIME_MAX, "tag time out of range")
    `ASSERT_SAME(a_idle_clear, aclk, aresetn, phase_reg == PH_IDLE, min_cnt_reg == 2'd0 && sec_cnt_reg == 2'd0 && frac_cnt_reg == 2'd0, "idle parser holds tag fields")
    `ASSERT_SAME(a_sec_has_min, aclk, aresetn, phase_reg == PH_SEC || phase_reg == PH_FRAC, min_cnt_reg != 2'd0, "seconds reached without minute digits")
    `ASSERT_NEXT(a_in_held, aclk, aresetn, in_valid_reg && !proceed, in_valid_reg && $stable(in_byte_reg), "stalled byte lost")

endmodule
